@@ rtl/sip_call_state_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// SIP call state tracker assertion macros
// Concurrent assertion shorthands; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef SIP_CALL_STATE_TRACKER_DEFINES_SVH
`define SIP_CALL_STATE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define SCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sct assertion failed");
// Next-cycle implication, sampled on clk, off during rst.
`define SCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sct assertion failed");
`else
`define SCT_ASSERT_NOW(label, ante, cons)
`define SCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// SIP call state tracker package
// State and class codes, queue entry types and the transition tables.
// ----------------------------------------------------------------------------
package sct_pkg;

  // Default depth of the internal queues
  localparam int unsigned QUEUE_DEPTH = 2;

  // Message kind
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_RESP = 2'd1;

  // Direction
  localparam logic [1:0] DIR_SENT = 2'd0;
  localparam logic [1:0] DIR_RCVD = 2'd1;

  // Method
  localparam logic [2:0] METH_INVITE = 3'd0;
  localparam logic [2:0] METH_CANCEL = 3'd1;
  localparam logic [2:0] METH_ACK    = 3'd2;
  localparam logic [2:0] METH_BYE    = 3'd3;

  // Status code ranges
  localparam logic [9:0] STATUS_1XX_LO = 10'd100;
  localparam logic [9:0] STATUS_1XX_HI = 10'd199;
  localparam logic [9:0] STATUS_2XX_LO = 10'd200;
  localparam logic [9:0] STATUS_2XX_HI = 10'd299;

  // Message class
  localparam logic [2:0] MC_NONE   = 3'd0;
  localparam logic [2:0] MC_INVITE = 3'd1;
  localparam logic [2:0] MC_CANCEL = 3'd2;
  localparam logic [2:0] MC_ACK    = 3'd3;
  localparam logic [2:0] MC_BYE    = 3'd4;
  localparam logic [2:0] MC_1XX    = 3'd5;
  localparam logic [2:0] MC_2XX    = 3'd6;
  localparam logic [2:0] MC_NON2XX = 3'd7;

  // Call state; zero marks "no transition" in the tables
  localparam logic [4:0] CS_NONE            = 5'd0;
  localparam logic [4:0] CS_IDLE            = 5'd1;
  localparam logic [4:0] CS_INV_SENT        = 5'd2;
  localparam logic [4:0] CS_INV_1XX_RCVD    = 5'd3;
  localparam logic [4:0] CS_INV_2XX_RCVD    = 5'd4;
  localparam logic [4:0] CS_INV_NON2XX_RCVD = 5'd5;
  localparam logic [4:0] CS_INV_RCVD        = 5'd6;
  localparam logic [4:0] CS_INV_1XX_SENT    = 5'd7;
  localparam logic [4:0] CS_INV_2XX_SENT    = 5'd8;
  localparam logic [4:0] CS_INV_NON2XX_SENT = 5'd9;
  localparam logic [4:0] CS_RE_SENT         = 5'd10;
  localparam logic [4:0] CS_RE_1XX_RCVD     = 5'd11;
  localparam logic [4:0] CS_RE_2XX_RCVD     = 5'd12;
  localparam logic [4:0] CS_RE_NON2XX_RCVD  = 5'd13;
  localparam logic [4:0] CS_RE_RCVD         = 5'd14;
  localparam logic [4:0] CS_RE_1XX_SENT     = 5'd15;
  localparam logic [4:0] CS_RE_2XX_SENT     = 5'd16;
  localparam logic [4:0] CS_RE_NON2XX_SENT  = 5'd17;
  localparam logic [4:0] CS_ESTAB           = 5'd18;
  localparam logic [4:0] CS_INV_CANCELLED   = 5'd19;
  localparam logic [4:0] CS_RE_CANCELLED    = 5'd20;
  localparam logic [4:0] CS_BYE_SENT        = 5'd21;
  localparam logic [4:0] CS_BYE_RCVD        = 5'd22;
  localparam logic [4:0] CS_TERMINATED      = 5'd23;

  // Classified message, front to back
  typedef struct packed {
    logic [2:0] cls;
    logic [1:0] direction;
    logic       resp_cancel;  // response to CANCEL
    logic       resp_bye;     // response to BYE
  } cmd_t;

  // Result entry, back to output queue
  typedef struct packed {
    logic [4:0] dialog_state;
    logic       changed;
    logic [2:0] message_class;
  } res_t;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  // Transition on a sent message
  function automatic logic [4:0] next_sent(input logic [4:0] st, input logic [2:0] cls);
    logic [4:0] nxt;
    nxt = CS_NONE;
    case (st)
      CS_IDLE:            if (cls == MC_INVITE) nxt = CS_INV_SENT;
      CS_INV_1XX_RCVD:    if (cls == MC_BYE) nxt = CS_INV_1XX_RCVD;
      CS_INV_2XX_RCVD:    if (cls == MC_ACK) nxt = CS_ESTAB;
      CS_INV_NON2XX_RCVD: if (cls == MC_ACK) nxt = CS_IDLE;
      CS_INV_RCVD, CS_INV_1XX_SENT: begin
        if (cls == MC_1XX) nxt = CS_INV_1XX_SENT;
        else if (cls == MC_2XX) nxt = CS_INV_2XX_SENT;
        else if (cls == MC_NON2XX) nxt = CS_INV_NON2XX_SENT;
      end
      CS_INV_2XX_SENT, CS_RE_SENT, CS_RE_1XX_RCVD: begin
        if (cls == MC_BYE) nxt = CS_BYE_SENT;
      end
      CS_RE_2XX_RCVD, CS_RE_NON2XX_RCVD: begin
        if (cls == MC_ACK) nxt = CS_ESTAB;
      end
      CS_RE_RCVD, CS_RE_1XX_SENT: begin
        if (cls == MC_1XX) nxt = CS_RE_1XX_SENT;
        else if (cls == MC_2XX) nxt = CS_RE_2XX_SENT;
        else if (cls == MC_NON2XX) nxt = CS_RE_NON2XX_SENT;
      end
      CS_ESTAB: begin
        if (cls == MC_INVITE) nxt = CS_RE_SENT;
        else if (cls == MC_BYE) nxt = CS_BYE_SENT;
      end
      CS_INV_CANCELLED: begin
        if (cls == MC_2XX) nxt = CS_INV_2XX_SENT;
        else if (cls == MC_NON2XX) nxt = CS_INV_NON2XX_SENT;
      end
      CS_RE_CANCELLED: begin
        if (cls == MC_2XX) nxt = CS_RE_2XX_SENT;
        else if (cls == MC_NON2XX) nxt = CS_RE_NON2XX_SENT;
      end
      CS_BYE_RCVD: begin
        if (cls == MC_2XX) nxt = CS_TERMINATED;
        else if (cls == MC_NON2XX) nxt = CS_ESTAB;
      end
      default: nxt = CS_NONE;
    endcase
    return nxt;
  endfunction

  // Transition on a received message
  function automatic logic [4:0] next_rcvd(input logic [4:0] st, input logic [2:0] cls);
    logic [4:0] nxt;
    nxt = CS_NONE;
    case (st)
      CS_IDLE: if (cls == MC_INVITE) nxt = CS_INV_RCVD;
      CS_INV_SENT, CS_INV_1XX_RCVD: begin
        if (cls == MC_1XX) nxt = CS_INV_1XX_RCVD;
        else if (cls == MC_2XX) nxt = CS_INV_2XX_RCVD;
        else if (cls == MC_NON2XX) nxt = CS_INV_NON2XX_RCVD;
      end
      CS_INV_2XX_RCVD: if (cls == MC_BYE) nxt = CS_BYE_RCVD;
      CS_INV_RCVD:     if (cls == MC_CANCEL) nxt = CS_INV_CANCELLED;
      CS_INV_1XX_SENT: begin
        if (cls == MC_CANCEL || cls == MC_BYE) nxt = CS_INV_CANCELLED;
      end
      CS_INV_2XX_SENT, CS_INV_NON2XX_SENT, CS_RE_2XX_SENT, CS_RE_NON2XX_SENT: begin
        // CANCEL and BYE self loop; ACK moves on
        if (cls == MC_CANCEL || cls == MC_BYE) nxt = st;
        else if (cls == MC_ACK) nxt = (st == CS_INV_NON2XX_SENT) ? CS_IDLE : CS_ESTAB;
      end
      CS_RE_SENT, CS_RE_1XX_RCVD: begin
        if (cls == MC_BYE) nxt = CS_BYE_RCVD;
        else if (cls == MC_1XX) nxt = CS_RE_1XX_RCVD;
        else if (cls == MC_2XX) nxt = CS_RE_2XX_RCVD;
        else if (cls == MC_NON2XX) nxt = CS_RE_NON2XX_RCVD;
      end
      CS_RE_2XX_RCVD, CS_RE_NON2XX_RCVD: begin
        if (cls == MC_BYE) nxt = CS_BYE_RCVD;
      end
      CS_RE_RCVD, CS_RE_1XX_SENT: begin
        if (cls == MC_CANCEL) nxt = CS_RE_CANCELLED;
        else if (cls == MC_BYE) nxt = CS_BYE_RCVD;
      end
      CS_ESTAB: begin
        if (cls == MC_INVITE) nxt = CS_RE_RCVD;
        else if (cls == MC_CANCEL || cls == MC_ACK) nxt = CS_ESTAB;
        else if (cls == MC_BYE) nxt = CS_BYE_RCVD;
      end
      CS_INV_CANCELLED: begin
        if (cls == MC_BYE || cls == MC_CANCEL) nxt = CS_INV_CANCELLED;
      end
      CS_BYE_SENT: begin
        if (cls == MC_ACK) nxt = CS_BYE_SENT;
        else if (cls == MC_BYE) nxt = CS_BYE_RCVD;
        else if (cls == MC_2XX) nxt = CS_TERMINATED;
        else if (cls == MC_NON2XX) nxt = CS_ESTAB;
      end
      default: nxt = CS_NONE;
    endcase
    return nxt;
  endfunction

endpackage

@@ rtl/sct_fifo.sv @@
// ----------------------------------------------------------------------------
// SCT queue
// Small first-word-fall-through queue between pipeline parts.
// ----------------------------------------------------------------------------
module sct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage; no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/sct_front.sv @@
// ----------------------------------------------------------------------------
// SCT front end
// Classifies each incoming message and flags responses that may be blocked.
// ----------------------------------------------------------------------------
module sct_front (
  input  logic          [1:0] kind,
  input  logic          [1:0] direction,
  input  logic          [2:0] method,
  input  logic          [9:0] status_code,
  output sct_pkg::cmd_t       cmd
);

  import sct_pkg::*;

  logic       is_1xx;
  logic       is_2xx;
  logic       known_method;
  logic [2:0] cls;

  assign is_1xx = (status_code >= STATUS_1XX_LO) && (status_code <= STATUS_1XX_HI);
  assign is_2xx = (status_code >= STATUS_2XX_LO) && (status_code <= STATUS_2XX_HI);
  assign known_method = (method <= METH_BYE);

  // Message class
  always_comb begin
    cls = MC_NONE;
    if (known_method) begin
      case (kind)
        KIND_REQ:  cls = method + 3'd1;
        KIND_RESP: cls = is_1xx ? MC_1XX : (is_2xx ? MC_2XX : MC_NON2XX);
        default:   cls = MC_NONE;
      endcase
    end
  end

  // Queue entry
  always_comb begin
    cmd.cls         = cls;
    cmd.direction   = direction;
    cmd.resp_cancel = (kind == KIND_RESP) && (method == METH_CANCEL);
    cmd.resp_bye    = (kind == KIND_RESP) && (method == METH_BYE);
  end

endmodule

@@ rtl/sct_back.sv @@
// ----------------------------------------------------------------------------
// SCT back end
// Holds the call state and applies one classified message per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`include "sip_call_state_tracker_defines.svh"

module sct_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  sct_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output sct_pkg::res_t res
);

  import sct_pkg::*;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [4:0] hop;
  logic [4:0] fold;
  logic       blocked;
  logic       hit;
  logic       take;
  logic       fold_land;

  assign take     = cmd_valid && !res_full;
  assign cmd_pop  = take;
  assign res_push = take;

  // Responses to CANCEL never move; responses to BYE only in the BYE states
  assign blocked = cmd.resp_cancel ||
                   (cmd.resp_bye && (state != CS_BYE_SENT) && (state != CS_BYE_RCVD));

  // Table lookup
  always_comb begin
    hop  = CS_NONE;
    fold = CS_NONE;
    if (cmd.cls != MC_NONE && !blocked) begin
      case (cmd.direction)
        DIR_SENT: begin
          hop = next_sent(state, cmd.cls);
          if (hop == CS_RE_NON2XX_SENT) fold = next_rcvd(hop, MC_ACK);
        end
        DIR_RCVD: begin
          hop = next_rcvd(state, cmd.cls);
          if (hop == CS_INV_NON2XX_RCVD || hop == CS_RE_NON2XX_RCVD) begin
            fold = next_sent(hop, MC_ACK);
          end
        end
        default: hop = CS_NONE;
      endcase
    end
  end

  assign hit = (hop != CS_NONE);

  // Next state with the implied ACK folded in
  always_comb begin
    state_next = state;
    if (hit) begin
      state_next = (fold != CS_NONE) ? fold : hop;
    end
  end

  always_comb begin
    res.dialog_state  = state_next;
    res.changed       = hit;
    res.message_class = cmd.cls;
  end

  // Call state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else if (take) begin
      state <= state_next;
    end
  end

  // Landing states that the implied ACK always moves on from
  assign fold_land = (state == CS_RE_NON2XX_SENT) || (state == CS_INV_NON2XX_RCVD) ||
                     (state == CS_RE_NON2XX_RCVD);

  `SCT_ASSERT_NOW(a_state_legal, 1'b1, (state >= CS_IDLE) && (state <= CS_TERMINATED))
  `SCT_ASSERT_NOW(a_no_fold_land, 1'b1, !fold_land)
  `SCT_ASSERT_NOW(a_change_has_class, take && res.changed, res.message_class != MC_NONE)
  `SCT_ASSERT_NEXT(a_blocked_holds, take && blocked, $stable(state))

endmodule

@@ rtl/sip_call_state_tracker.sv @@
// ----------------------------------------------------------------------------
// SIP call state tracker
// Follows the signalling state of one call, one message per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive kind, direction, method and status_code and raise
//   push; the transaction is taken on a clock edge where full is low.
//   Output channel: while empty is low, dialog_state, changed and
//   message_class show the oldest result; pop takes it.
//   Each message gives exactly one result, in order.
// Path: a message passes two register stages, the classified-message queue,
//   then the result queue written by the state update.
// Throughput: one message per cycle while the result queue has room; the state
//   update is a table lookup, plus a second one for an implied ACK.
// Reset: rst is synchronous; both queues empty and the call state goes idle.
// Stall: if pop stays low the result queue fills, then the message queue,
//   then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module sip_call_state_tracker #(
  parameter int unsigned QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [1:0] direction,
  input  logic [2:0] method,
  input  logic [9:0] status_code,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] dialog_state,
  output logic       changed,
  output logic [2:0] message_class
);

  import sct_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_out;
  res_t res_in;
  res_t res_out;
  logic cmd_empty;
  logic cmd_pop;
  logic res_full;
  logic res_push;

  // Classification
  sct_front u_front (
    .kind        (kind),
    .direction   (direction),
    .method      (method),
    .status_code (status_code),
    .cmd         (cmd_in)
  );

  // Classified message queue
  sct_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // State update
  sct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue
  sct_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign dialog_state  = res_out.dialog_state;
  assign changed       = res_out.changed;
  assign message_class = res_out.message_class;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// SIP call state tracker testbench
// Drives sent and received SIP messages through the tracker's input queue
// and checks every result against a cycle-free model of the call state
// machine. Stimulus is a short directed walk, then random messages that
// mostly follow legal dialog steps, plus noise and protocol misuse. Both
// queue sides idle at random, and the result side holds off once long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  // Field codes the package leaves out
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_MAX    = 2'd3;
  localparam logic [1:0] DIR_INVALID = 2'd2;
  localparam logic [1:0] DIR_MAX     = 2'd3;
  localparam logic [2:0] METH_OTHER  = 3'd4;
  localparam logic [2:0] METH_MAX    = 3'd7;

  localparam int unsigned TOTAL_MSGS     = 1050;
  localparam int unsigned TERM_ALLOWED   = 800;   // terminated is absorbing
  localparam int unsigned IDLE_PCT       = 18;
  localparam int unsigned BUSY_LO        = 500;   // no idling in this window
  localparam int unsigned BUSY_HI        = 700;
  localparam int unsigned HOLD_AT        = 250;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] direction;
    logic [2:0] method;
    logic [9:0] status;
  } sip_msg_t;

  typedef struct packed {
    logic [4:0] dialog_state;
    logic       changed;
    logic [2:0] message_class;
  } call_outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] kind = '0;
  logic [1:0] direction = '0;
  logic [2:0] method = '0;
  logic [9:0] status_code = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic [4:0] dialog_state;
  logic       changed;
  logic [2:0] message_class;

  sip_msg_t      msg_backlog[$];
  call_outcome_t outcome_q[$];
  int unsigned   mismatch_cnt = 0;

  sip_call_state_tracker i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .direction    (direction),
    .method       (method),
    .status_code  (status_code),
    .empty        (empty),
    .pop          (pop),
    .dialog_state (dialog_state),
    .changed      (changed),
    .message_class(message_class)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Call state model
  // --------------------------------------------------------------------------

  function automatic logic [2:0] msg_class(sip_msg_t m);
    if (m.method > METH_BYE) return MC_NONE;
    if (m.kind == KIND_REQ) return m.method + 3'd1;
    if (m.kind != KIND_RESP) return MC_NONE;
    if (m.status >= STATUS_1XX_LO && m.status <= STATUS_1XX_HI) return MC_1XX;
    if (m.status >= STATUS_2XX_LO && m.status <= STATUS_2XX_HI) return MC_2XX;
    return MC_NON2XX;
  endfunction

  // Next state for a message we sent, organized by message class
  function automatic logic [4:0] after_sent(logic [4:0] st, logic [2:0] cls);
    logic [4:0] dest;
    dest = CS_NONE;
    case (cls)
      MC_INVITE: begin
        if (st == CS_IDLE) dest = CS_INV_SENT;
        else if (st == CS_ESTAB) dest = CS_RE_SENT;
      end
      MC_ACK: begin
        case (st)
          CS_INV_2XX_RCVD, CS_RE_2XX_RCVD, CS_RE_NON2XX_RCVD: dest = CS_ESTAB;
          CS_INV_NON2XX_RCVD: dest = CS_IDLE;
          default: dest = CS_NONE;
        endcase
      end
      MC_BYE: begin
        case (st)
          CS_INV_1XX_RCVD: dest = CS_INV_1XX_RCVD;
          CS_INV_2XX_SENT, CS_RE_SENT, CS_RE_1XX_RCVD, CS_ESTAB: dest = CS_BYE_SENT;
          default: dest = CS_NONE;
        endcase
      end
      MC_1XX: begin
        case (st)
          CS_INV_RCVD, CS_INV_1XX_SENT: dest = CS_INV_1XX_SENT;
          CS_RE_RCVD, CS_RE_1XX_SENT: dest = CS_RE_1XX_SENT;
          default: dest = CS_NONE;
        endcase
      end
      MC_2XX: begin
        case (st)
          CS_INV_RCVD, CS_INV_1XX_SENT, CS_INV_CANCELLED: dest = CS_INV_2XX_SENT;
          CS_RE_RCVD, CS_RE_1XX_SENT, CS_RE_CANCELLED: dest = CS_RE_2XX_SENT;
          CS_BYE_RCVD: dest = CS_TERMINATED;
          default: dest = CS_NONE;
        endcase
      end
      MC_NON2XX: begin
        case (st)
          CS_INV_RCVD, CS_INV_1XX_SENT, CS_INV_CANCELLED: dest = CS_INV_NON2XX_SENT;
          CS_RE_RCVD, CS_RE_1XX_SENT, CS_RE_CANCELLED: dest = CS_RE_NON2XX_SENT;
          CS_BYE_RCVD: dest = CS_ESTAB;
          default: dest = CS_NONE;
        endcase
      end
      default: dest = CS_NONE;
    endcase
    return dest;
  endfunction

  // Next state for a message we received, organized by message class
  function automatic logic [4:0] after_rcvd(logic [4:0] st, logic [2:0] cls);
    logic [4:0] dest;
    dest = CS_NONE;
    case (cls)
      MC_INVITE: begin
        if (st == CS_IDLE) dest = CS_INV_RCVD;
        else if (st == CS_ESTAB) dest = CS_RE_RCVD;
      end
      MC_CANCEL: begin
        case (st)
          CS_INV_RCVD, CS_INV_1XX_SENT: dest = CS_INV_CANCELLED;
          CS_RE_RCVD, CS_RE_1XX_SENT: dest = CS_RE_CANCELLED;
          CS_INV_2XX_SENT, CS_INV_NON2XX_SENT, CS_RE_2XX_SENT, CS_RE_NON2XX_SENT,
          CS_ESTAB, CS_INV_CANCELLED: dest = st;
          default: dest = CS_NONE;
        endcase
      end
      MC_ACK: begin
        case (st)
          CS_INV_2XX_SENT, CS_RE_2XX_SENT, CS_RE_NON2XX_SENT, CS_ESTAB: dest = CS_ESTAB;
          CS_INV_NON2XX_SENT: dest = CS_IDLE;
          CS_BYE_SENT: dest = CS_BYE_SENT;
          default: dest = CS_NONE;
        endcase
      end
      MC_BYE: begin
        case (st)
          CS_INV_2XX_RCVD, CS_RE_SENT, CS_RE_1XX_RCVD, CS_RE_2XX_RCVD,
          CS_RE_NON2XX_RCVD, CS_RE_RCVD, CS_RE_1XX_SENT, CS_ESTAB,
          CS_BYE_SENT: dest = CS_BYE_RCVD;
          CS_INV_1XX_SENT: dest = CS_INV_CANCELLED;
          CS_INV_2XX_SENT, CS_INV_NON2XX_SENT, CS_RE_2XX_SENT, CS_RE_NON2XX_SENT,
          CS_INV_CANCELLED: dest = st;
          default: dest = CS_NONE;
        endcase
      end
      MC_1XX: begin
        case (st)
          CS_INV_SENT, CS_INV_1XX_RCVD: dest = CS_INV_1XX_RCVD;
          CS_RE_SENT, CS_RE_1XX_RCVD: dest = CS_RE_1XX_RCVD;
          default: dest = CS_NONE;
        endcase
      end
      MC_2XX: begin
        case (st)
          CS_INV_SENT, CS_INV_1XX_RCVD: dest = CS_INV_2XX_RCVD;
          CS_RE_SENT, CS_RE_1XX_RCVD: dest = CS_RE_2XX_RCVD;
          CS_BYE_SENT: dest = CS_TERMINATED;
          default: dest = CS_NONE;
        endcase
      end
      MC_NON2XX: begin
        case (st)
          CS_INV_SENT, CS_INV_1XX_RCVD: dest = CS_INV_NON2XX_RCVD;
          CS_RE_SENT, CS_RE_1XX_RCVD: dest = CS_RE_NON2XX_RCVD;
          CS_BYE_SENT: dest = CS_ESTAB;
          default: dest = CS_NONE;
        endcase
      end
      default: dest = CS_NONE;
    endcase
    return dest;
  endfunction

  // One message applied to a call state
  function automatic call_outcome_t call_step(logic [4:0] st, sip_msg_t m);
    call_outcome_t o;
    logic [2:0]    cls;
    logic [4:0]    dest;
    logic          blocked;
    cls     = msg_class(m);
    blocked = 1'b0;
    // responses to CANCEL never move; responses to BYE only in the BYE states
    if (cls != MC_NONE && m.kind == KIND_RESP) begin
      if (m.method == METH_CANCEL) blocked = 1'b1;
      else if (m.method == METH_BYE && st != CS_BYE_SENT && st != CS_BYE_RCVD)
        blocked = 1'b1;
    end
    o.changed       = 1'b0;
    o.message_class = cls;
    if (cls != MC_NONE && !blocked) begin
      if (m.direction == DIR_SENT) begin
        dest = after_sent(st, cls);
        if (dest != CS_NONE) begin
          o.changed = 1'b1;
          st = dest;
          // implied ACK received
          if (st == CS_RE_NON2XX_SENT) st = after_rcvd(st, MC_ACK);
        end
      end else if (m.direction == DIR_RCVD) begin
        dest = after_rcvd(st, cls);
        if (dest != CS_NONE) begin
          o.changed = 1'b1;
          st = dest;
          // implied ACK sent
          if (st == CS_INV_NON2XX_RCVD || st == CS_RE_NON2XX_RCVD)
            st = after_sent(st, MC_ACK);
        end
      end
    end
    o.dialog_state = st;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  function automatic logic [9:0] pick_status();
    case ($urandom_range(0, 9))
      0, 1, 2: return 10'($urandom_range(100, 199));
      3, 4, 5: return 10'($urandom_range(200, 299));
      6:       return 10'($urandom_range(0, 99));
      7:       return 10'($urandom_range(300, 1023));
      8: begin
        case ($urandom_range(0, 7))
          0: return 10'd0;
          1: return 10'd99;
          2: return 10'd100;
          3: return 10'd199;
          4: return 10'd200;
          5: return 10'd299;
          6: return 10'd300;
          default: return 10'd1023;
        endcase
      end
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  logic [4:0]  plan_state = CS_IDLE;
  int unsigned counted = 0;

  // Queue one message; keeps the call away from terminated until late
  task automatic queue_msg(sip_msg_t m);
    call_outcome_t o;
    o = call_step(plan_state, m);
    if (o.dialog_state == CS_TERMINATED && plan_state != CS_TERMINATED &&
        counted < TERM_ALLOWED) begin
      m.method = METH_OTHER;
      o = call_step(plan_state, m);
    end
    plan_state = o.dialog_state;
    if (o.message_class != MC_NONE) counted++;
    msg_backlog.push_back(m);
  endtask

  task automatic queue_fields(logic [1:0] k, logic [1:0] d, logic [2:0] mt, logic [9:0] s);
    sip_msg_t m;
    m.kind      = k;
    m.direction = d;
    m.method    = mt;
    m.status    = s;
    queue_msg(m);
  endtask

  // Mostly legal dialog steps: try random messages until one moves the call
  task automatic queue_random();
    sip_msg_t      m;
    call_outcome_t o;
    int            tries;
    if ($urandom_range(0, 99) < 20) begin
      m.kind      = 2'($urandom_range(0, KIND_MAX));
      m.direction = 2'($urandom_range(0, DIR_MAX));
      m.method    = 3'($urandom_range(0, METH_MAX));
      m.status    = 10'($urandom_range(0, 1023));
    end else begin
      for (tries = 0; tries < 40; tries++) begin
        m.kind      = 2'($urandom_range(KIND_REQ, KIND_RESP));
        m.direction = 2'($urandom_range(DIR_SENT, DIR_RCVD));
        m.method    = 3'($urandom_range(METH_INVITE, METH_BYE));
        m.status    = pick_status();
        o = call_step(plan_state, m);
        if (o.changed && (o.dialog_state != CS_TERMINATED || counted >= TERM_ALLOWED))
          break;
      end
    end
    queue_msg(m);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers backlog messages, predicts each accepted transaction
  // --------------------------------------------------------------------------
  logic [4:0]    model_state = CS_IDLE;
  sip_msg_t      offered = '0;
  int unsigned   tx_count = 0;

  always @(posedge clk) begin
    call_outcome_t o;
    logic          lazy;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        o = call_step(model_state, offered);
        model_state = o.dialog_state;
        outcome_q.push_back(o);
        tx_count++;
      end
      // a stalled offer stays on the bus
      if (!(push && full)) begin
        lazy = ($urandom_range(0, 99) < IDLE_PCT) &&
               !(tx_count >= BUSY_LO && tx_count < BUSY_HI);
        if (!lazy && msg_backlog.size() > 0) begin
          offered = msg_backlog.pop_front();
          push        <= 1'b1;
          kind        <= offered.kind;
          direction   <= offered.direction;
          method      <= offered.method;
          status_code <= offered.status;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: pops results and compares them with the oldest prediction
  // --------------------------------------------------------------------------
  int unsigned rx_count = 0;
  int unsigned hold_left = 0;
  logic        held = 1'b0;

  always @(posedge clk) begin
    call_outcome_t want;
    logic          lazy;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        rx_count++;
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected result: state %0d changed %0b class %0d",
                     $realtime, dialog_state, changed, message_class);
        end else begin
          want = outcome_q.pop_front();
          if (dialog_state !== want.dialog_state || changed !== want.changed ||
              message_class !== want.message_class) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("[%0t] result %0d mismatch: state %0d/%0d changed %0b/%0b class %0d/%0d",
                       $realtime, rx_count, dialog_state, want.dialog_state, changed,
                       want.changed, message_class, want.message_class);
          end
        end
      end
      // one long hold-off so the block fills and pushes back
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_count == HOLD_AT && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        lazy = ($urandom_range(0, 99) < IDLE_PCT) &&
               !(rx_count >= BUSY_LO && rx_count < BUSY_HI);
        pop <= !lazy;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transaction on either side
  // --------------------------------------------------------------------------
  int unsigned stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // ignored kinds and methods, invalid modes
    queue_fields(KIND_OTHER, DIR_SENT, METH_INVITE, 10'd0);
    queue_fields(KIND_MAX, DIR_RCVD, METH_MAX, 10'd1023);
    queue_fields(KIND_REQ, DIR_SENT, METH_OTHER, 10'd0);
    queue_fields(KIND_REQ, DIR_INVALID, METH_INVITE, 10'd0);
    queue_fields(KIND_REQ, DIR_MAX, METH_INVITE, 10'd0);
    // outgoing call, provisional, then responses to CANCEL and BYE that stay put
    queue_fields(KIND_REQ, DIR_SENT, METH_INVITE, 10'd0);
    queue_fields(KIND_RESP, DIR_RCVD, METH_INVITE, 10'd100);
    queue_fields(KIND_RESP, DIR_RCVD, METH_CANCEL, 10'd200);
    queue_fields(KIND_RESP, DIR_RCVD, METH_BYE, 10'd200);
    queue_fields(KIND_REQ, DIR_SENT, METH_BYE, 10'd0);
    // failure received: implied ACK back to idle
    queue_fields(KIND_RESP, DIR_RCVD, METH_INVITE, 10'd99);
    // incoming call answered
    queue_fields(KIND_REQ, DIR_RCVD, METH_INVITE, 10'd0);
    queue_fields(KIND_RESP, DIR_SENT, METH_INVITE, 10'd180);
    queue_fields(KIND_RESP, DIR_SENT, METH_INVITE, 10'd299);
    queue_fields(KIND_REQ, DIR_RCVD, METH_ACK, 10'd0);
    // re-INVITE out and in, failure sent folds back to established
    queue_fields(KIND_REQ, DIR_SENT, METH_INVITE, 10'd0);
    queue_fields(KIND_RESP, DIR_RCVD, METH_INVITE, 10'd200);
    queue_fields(KIND_REQ, DIR_SENT, METH_ACK, 10'd0);
    queue_fields(KIND_REQ, DIR_RCVD, METH_INVITE, 10'd0);
    queue_fields(KIND_RESP, DIR_SENT, METH_INVITE, 10'd1023);
    queue_fields(KIND_REQ, DIR_RCVD, METH_CANCEL, 10'd0);
    // BYE both ways with failing answers and an ignored provisional one
    queue_fields(KIND_REQ, DIR_SENT, METH_BYE, 10'd0);
    queue_fields(KIND_RESP, DIR_RCVD, METH_BYE, 10'd300);
    queue_fields(KIND_REQ, DIR_RCVD, METH_BYE, 10'd0);
    queue_fields(KIND_RESP, DIR_SENT, METH_BYE, 10'd199);
    queue_fields(KIND_RESP, DIR_SENT, METH_BYE, 10'd0);

    counted = 0;
    while (msg_backlog.size() < TOTAL_MSGS) queue_random();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (msg_backlog.size() != 0 || push || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sct_pkg.sv
rtl/sct_fifo.sv
rtl/sct_front.sv
rtl/sct_back.sv
rtl/sip_call_state_tracker.sv
verif/tb_top.sv
